@@ src/bds_pkg.sv @@
//------------------------------------------------------------------------------
// bds_pkg
// Shared types and command/status structures of the descriptive statistics
// block.
//------------------------------------------------------------------------------
`default_nettype none
package bds_pkg;

  localparam int DEPTH        = 1024;
  localparam int SAMPLE_WIDTH = 16;
  localparam int COUNT_W      = $clog2(DEPTH + 1);

  typedef struct packed {
    logic signed [15:0] sample;
    logic               last_sample;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] minimum;
    logic signed [15:0] maximum;
    logic signed [23:0] mean_q8;
    logic [15:0]        spread;
    logic [46:0]        variance_q16;
    logic [23:0]        std_dev_q8;
    logic               overflowed;
    logic [10:0]        sample_count;
  } out_word_t;

  typedef struct packed {
    logic load;
    logic mean_start;
    logic pass_start;
    logic pass_step;
    logic var_start;
    logic sqrt_start;
    logic finish;
    logic clear;
  } dp_cmd_t;

  typedef struct packed {
    logic               mean_done;
    logic               pass_done;
    logic               var_done;
    logic               sqrt_done;
    logic               last_seen;
    logic [COUNT_W-1:0] count;
  } dp_status_t;

endpackage
`default_nettype wire

@@ src/bds_ram.sv @@
//------------------------------------------------------------------------------
// bds_ram
// Generic single-port-write, single-port-read RAM with registered read data.
//------------------------------------------------------------------------------
`default_nettype none
module bds_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ src/bds_datapath.sv @@
//------------------------------------------------------------------------------
// bds_datapath
// Sample store, running statistics, serial divider, second pass accumulator
// and serial square root.
//------------------------------------------------------------------------------
`default_nettype none
module bds_datapath (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire bds_pkg::in_word_t  in_word,
  input  wire bds_pkg::dp_cmd_t   cmd,
  output bds_pkg::dp_status_t     status,
  output bds_pkg::out_word_t      result
);

  localparam int DEPTH = bds_pkg::DEPTH;
  localparam int AW  = $clog2(DEPTH);
  localparam int CW  = bds_pkg::COUNT_W;
  localparam int SW  = bds_pkg::SAMPLE_WIDTH;
  localparam int SUMW = SW + CW;
  localparam int NUMW = SUMW + 8;
  localparam int DW  = SW + 10;
  localparam int ACCW = 64;
  localparam int ROOTW = 32;

  logic [CW-1:0]          count;
  logic signed [SUMW-1:0] running_sum;
  logic signed [SW-1:0]   running_min;
  logic signed [SW-1:0]   running_max;
  logic                   dropped;
  logic                   last_seen;
  logic signed [SW-1:0]   s;
  logic                   room;

  assign s    = in_word.sample[SW-1:0];
  assign room = (count < CW'(DEPTH));

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      count       <= '0;
      running_sum <= '0;
      running_min <= '0;
      running_max <= '0;
      dropped     <= 1'b0;
      last_seen   <= 1'b0;
    end else if (cmd.load) begin
      last_seen <= in_word.last_sample;
      if (room) begin
        count       <= count + 1'b1;
        running_sum <= running_sum + SUMW'(s);
        if (count == '0 || s < running_min) running_min <= s;
        if (count == '0 || s > running_max) running_max <= s;
      end else begin
        dropped <= 1'b1;
      end
    end
  end

  // Sample store.
  logic [AW-1:0] raddr;
  logic [SW-1:0] rdata;

  bds_ram #(.WIDTH(SW), .DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (cmd.load && room),
    .waddr (count[AW-1:0]),
    .wdata (s),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Shared restoring divider: numerator magnitude by count, one bit a cycle.
  logic [ACCW-1:0] div_q;
  logic [CW:0]     div_r;
  logic [6:0]      div_cnt;
  logic            div_busy;
  logic            div_neg;
  logic            div_is_mean;
  logic            mean_done;
  logic            var_done;
  logic [CW:0]     div_try;
  logic [NUMW-1:0] num_mag;
  logic signed [NUMW-1:0] num;
  logic signed [DW-1:0]   mean;
  logic [ACCW-1:0] acc;
  logic [46:0]     variance;

  assign num     = {running_sum, 8'd0};
  assign num_mag = num[NUMW-1] ? NUMW'(-num) : num;
  assign div_try = {div_r[CW-1:0], div_q[ACCW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy  <= 1'b0;
      mean_done <= 1'b0;
      var_done  <= 1'b0;
    end else begin
      mean_done <= 1'b0;
      var_done  <= 1'b0;
      if (cmd.mean_start || cmd.var_start) begin
        div_busy    <= 1'b1;
        div_cnt     <= 7'(ACCW);
        div_r       <= '0;
        div_is_mean <= cmd.mean_start;
        div_neg     <= cmd.mean_start && num[NUMW-1];
        div_q       <= cmd.mean_start ? ACCW'(num_mag) : acc;
      end else if (div_busy) begin
        if (div_try >= {1'b0, count}) begin
          div_r <= div_try - {1'b0, count};
          div_q <= {div_q[ACCW-2:0], 1'b1};
        end else begin
          div_r <= div_try;
          div_q <= {div_q[ACCW-2:0], 1'b0};
        end
        div_cnt <= div_cnt - 1'b1;
        if (div_cnt == 7'd1) begin
          div_busy <= 1'b0;
          if (div_is_mean) mean_done <= 1'b1;
          else var_done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mean_done) begin
      mean <= div_neg ? -DW'(div_q) : DW'(div_q);
    end
    if (var_done) begin
      variance <= div_q[46:0];
    end
  end

  // Second pass: read, difference, square, accumulate.
  logic [CW-1:0] pass_idx;
  logic          rd_v;
  logic          sq_v;
  logic          pass_done;
  logic [CW-1:0] pass_left;
  logic [DW-1:0]      dmag;
  logic signed [DW:0] dtmp;

  assign raddr = pass_idx[AW-1:0];
  assign dtmp  = (DW+1)'($signed(rdata)) * (DW+1)'(256) - (DW+1)'(mean);

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v      <= 1'b0;
      sq_v      <= 1'b0;
      pass_done <= 1'b0;
      pass_left <= '0;
    end else begin
      pass_done <= 1'b0;
      rd_v      <= cmd.pass_step;
      sq_v      <= rd_v;
      if (cmd.pass_start) begin
        pass_idx  <= '0;
        pass_left <= count;
        acc       <= '0;
      end else begin
        if (cmd.pass_step) pass_idx <= pass_idx + 1'b1;
        if (rd_v) begin
          dmag <= dtmp[DW] ? DW'(-dtmp) : DW'(dtmp);
        end
        if (sq_v) begin
          acc       <= acc + ACCW'(dmag * dmag);
          pass_left <= pass_left - 1'b1;
          if (pass_left == CW'(1)) pass_done <= 1'b1;
        end
      end
    end
  end

  // Serial floor square root, one result bit a cycle.
  logic [ROOTW-1:0] root;
  logic [ROOTW+1:0] rem;
  logic [63:0]      rad;
  logic [5:0]       sq_cnt;
  logic             sq_busy;
  logic             sqrt_done;
  logic [ROOTW+1:0] trial;
  logic [ROOTW+1:0] rem_sh;

  assign rem_sh = {rem[ROOTW-1:0], rad[63:62]};
  assign trial  = {root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_busy   <= 1'b0;
      sqrt_done <= 1'b0;
    end else begin
      sqrt_done <= 1'b0;
      if (cmd.sqrt_start) begin
        sq_busy <= 1'b1;
        sq_cnt  <= 6'd32;
        rad     <= {17'd0, div_q[46:0]};
        rem     <= '0;
        root    <= '0;
      end else if (sq_busy) begin
        rad <= {rad[61:0], 2'b00};
        if (rem_sh >= trial) begin
          rem  <= rem_sh - trial;
          root <= {root[ROOTW-2:0], 1'b1};
        end else begin
          rem  <= rem_sh;
          root <= {root[ROOTW-2:0], 1'b0};
        end
        sq_cnt <= sq_cnt - 1'b1;
        if (sq_cnt == 6'd1) begin
          sq_busy   <= 1'b0;
          sqrt_done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      result.minimum      <= 16'(running_min);
      result.maximum      <= 16'(running_max);
      result.mean_q8      <= 24'(mean);
      result.spread       <= 16'(running_max - running_min);
      result.variance_q16 <= variance;
      result.std_dev_q8   <= root[23:0];
      result.overflowed   <= dropped;
      result.sample_count <= 11'(count);
    end
  end

  always_comb begin
    status.mean_done = mean_done;
    status.pass_done = pass_done;
    status.var_done  = var_done;
    status.sqrt_done = sqrt_done;
    status.last_seen = last_seen;
    status.count     = count;
  end

  property p_count_bound;
    @(posedge clk) disable iff (rst) count <= CW'(DEPTH);
  endproperty
  a_count_bound: assert property (p_count_bound) else $error("count above depth");

  property p_min_max;
    @(posedge clk) disable iff (rst) running_min <= running_max;
  endproperty
  a_min_max: assert property (p_min_max) else $error("minimum above maximum");

  property p_units_excl;
    @(posedge clk) disable iff (rst) !(div_busy && sq_busy);
  endproperty
  a_units_excl: assert property (p_units_excl) else $error("divider and root overlap");

endmodule
`default_nettype wire

@@ src/bds_ctrl.sv @@
//------------------------------------------------------------------------------
// bds_ctrl
// Sequencer: load, mean division, second pass, variance division, root, output.
//------------------------------------------------------------------------------
`default_nettype none
module bds_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  output logic                     out_valid,
  input  wire logic                out_stall,
  input  wire bds_pkg::dp_status_t status,
  output bds_pkg::dp_cmd_t         cmd
);

  localparam logic [2:0] S_LOAD = 3'd0;
  localparam logic [2:0] S_MEAN = 3'd1;
  localparam logic [2:0] S_PASS = 3'd2;
  localparam logic [2:0] S_VAR  = 3'd3;
  localparam logic [2:0] S_ROOT = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;
  localparam logic [2:0] S_KICK = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       issued;
  logic       kick;

  assign in_stall = (state != S_LOAD) || status.last_seen;

  always_comb begin
    cmd        = '0;
    state_next = state;
    kick       = 1'b0;
    unique case (state)
      S_LOAD: begin
        cmd.load = in_valid && !status.last_seen;
        if (status.last_seen) state_next = S_KICK;
      end
      S_KICK: begin
        cmd.mean_start = 1'b1;
        state_next     = S_MEAN;
      end
      S_MEAN: begin
        if (status.mean_done) begin
          cmd.pass_start = 1'b1;
          state_next     = S_PASS;
        end
      end
      S_PASS: begin
        cmd.pass_step = !issued;
        kick          = 1'b1;
        if (status.pass_done) begin
          cmd.var_start = 1'b1;
          state_next    = S_VAR;
        end
      end
      S_VAR: begin
        if (status.var_done) begin
          cmd.sqrt_start = 1'b1;
          state_next     = S_ROOT;
        end
      end
      S_ROOT: begin
        if (status.sqrt_done) begin
          cmd.finish = 1'b1;
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_stall) begin
          cmd.clear  = 1'b1;
          state_next = S_LOAD;
        end
      end
      default: state_next = S_LOAD;
    endcase
  end

  // Pass step counter: issue exactly count reads.
  logic [bds_pkg::COUNT_W-1:0] steps;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      out_valid <= 1'b0;
      issued    <= 1'b0;
      steps     <= '0;
    end else begin
      state <= state_next;
      if (cmd.finish) out_valid <= 1'b1;
      if (cmd.clear)  out_valid <= 1'b0;
      if (cmd.pass_start) begin
        issued <= 1'b0;
        steps  <= status.count;
      end else if (kick && !issued) begin
        steps <= steps - 1'b1;
        if (steps == bds_pkg::COUNT_W'(1)) issued <= 1'b1;
      end
    end
  end

  property p_out_state;
    @(posedge clk) disable iff (rst) out_valid |-> state == S_OUT;
  endproperty
  a_out_state: assert property (p_out_state) else $error("result shown outside output state");

  property p_stall_busy;
    @(posedge clk) disable iff (rst) (state != S_LOAD) |-> in_stall;
  endproperty
  a_stall_busy: assert property (p_stall_busy) else $error("input open while busy");

  property p_clear_after_out;
    @(posedge clk) disable iff (rst) cmd.clear |=> !out_valid;
  endproperty
  a_clear_after_out: assert property (p_clear_after_out) else $error("result held after delivery");

endmodule
`default_nettype wire

@@ src/block_descriptive_statistics.sv @@
//------------------------------------------------------------------------------
// block_descriptive_statistics
// Count, minimum, maximum, mean, spread, two-pass variance and standard deviation of a sample set.
//------------------------------------------------------------------------------
// Samples load into a DEPTH-entry store at one word per cycle while not stalled.
// After the closing word come the mean divider, the second pass over the store,
// the variance divider and the root; then the result word is valid.
// Input stalls until the result is taken.
// Synchronous active-high reset clears the sample count and running statistics.
`default_nettype none
module block_descriptive_statistics (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire bds_pkg::in_word_t   in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output bds_pkg::out_word_t       out_data
);

  bds_pkg::dp_cmd_t    cmd;
  bds_pkg::dp_status_t status;

  bds_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  bds_datapath u_dp (
    .clk     (clk),
    .rst     (rst),
    .in_word (in_data),
    .cmd     (cmd),
    .status  (status),
    .result  (out_data)
  );

endmodule
`default_nettype wire
